[rtl/tcmp_pkg.sv]
// Package for the two-column matrix product block.
// Constants, register codes, queue entry and configuration types.
// No dependencies.
package tcmp_pkg;

  localparam int MaxColumns = 2048;
  localparam int ColIdxW    = $clog2(MaxColumns);
  localparam int ColCntW    = $clog2(MaxColumns + 1);
  localparam int RowLenW    = 12;
  localparam int RowCntW    = 16;
  localparam int LvlCntW    = 16;
  localparam int LenCmpW    = (RowLenW > ColCntW) ? RowLenW : ColCntW;
  localparam int DataW      = 64;
  localparam int HalfW      = DataW / 2;
  localparam int AccW       = 2 * DataW;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);
  localparam int ApbAddrW   = 4;
  localparam int ApbDataW   = 32;

  localparam logic [1:0] RegRowLength  = 2'd0;
  localparam logic [1:0] RegRowCount   = 2'd1;
  localparam logic [1:0] RegLevelCount = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpData = 1'b1;

  typedef struct packed {
    logic [RowLenW-1:0] row_length;
    logic [RowCntW-1:0] row_count;
    logic [LvlCntW-1:0] level_count;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] db_value;
    logic [DataW-1:0] query_first;
    logic [DataW-1:0] query_second;
    logic             row_end;
    logic             level_done;
    logic             final_level;
  } qentry_t;

  function automatic logic [ColCntW-1:0] eff_columns(input logic [RowLenW-1:0] row_length);
    logic [LenCmpW-1:0] len_ext;
    len_ext = LenCmpW'(row_length);
    if (len_ext == '0) begin
      eff_columns = ColCntW'(1);
    end else if (len_ext > LenCmpW'(MaxColumns)) begin
      eff_columns = ColCntW'(MaxColumns);
    end else begin
      eff_columns = ColCntW'(len_ext);
    end
  endfunction

endpackage

[rtl/tcmp_feed_if.sv]
// Input channel: valid/ready handshake with one item per transfer.
// Depends on tcmp_pkg.
interface tcmp_feed_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [tcmp_pkg::DataW-1:0] db_value;
  logic [tcmp_pkg::DataW-1:0] query_first;
  logic [tcmp_pkg::DataW-1:0] query_second;

  modport source (output valid, opcode, db_value, query_first, query_second, input ready);
  modport sink (input valid, opcode, db_value, query_first, query_second, output ready);
endinterface

[rtl/tcmp_sums_if.sv]
// Result channel: valid/ready handshake carrying both row sums and flags.
// Depends on tcmp_pkg.
interface tcmp_sums_if;
  logic                      valid;
  logic                      ready;
  logic [tcmp_pkg::DataW-1:0] first_sum_low;
  logic [tcmp_pkg::DataW-1:0] first_sum_high;
  logic [tcmp_pkg::DataW-1:0] second_sum_low;
  logic [tcmp_pkg::DataW-1:0] second_sum_high;
  logic                      level_done;
  logic                      final_level;

  modport source (output valid, first_sum_low, first_sum_high, second_sum_low,
                  second_sum_high, level_done, final_level, input ready);
  modport sink (input valid, first_sum_low, first_sum_high, second_sum_low,
                second_sum_high, level_done, final_level, output ready);
endinterface

[rtl/tcmp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcmp_ram #(
  parameter int Width = 64,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tcmp_front.sv]
// Front end: accepts items, stores query pairs, tracks column, row and level
// positions and pushes database elements with their query pair into the queue.
// Depends on tcmp_pkg, tcmp_feed_if and tcmp_ram.
module tcmp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  tcmp_pkg::cfg_t           cfg,
  tcmp_feed_if.sink                feed,
  input  logic [tcmp_pkg::QCntW-1:0] q_count,
  output logic                     push,
  output tcmp_pkg::qentry_t        push_entry
);

  logic [tcmp_pkg::ColIdxW-1:0] load_ptr, load_ptr_next;
  logic [tcmp_pkg::ColIdxW-1:0] col_pos, col_pos_next;
  logic [tcmp_pkg::RowCntW-1:0] row_pos, row_pos_next;
  logic [tcmp_pkg::LvlCntW-1:0] lvl_pos, lvl_pos_next;
  logic [tcmp_pkg::ColCntW-1:0] cols;
  logic [tcmp_pkg::RowCntW-1:0] rows;
  logic [tcmp_pkg::LvlCntW-1:0] levels;
  logic                         accept, take_load, take_data;
  logic                         row_end, last_row, last_level;
  logic                         f_valid;
  logic [tcmp_pkg::DataW-1:0]   f_db;
  logic                         f_row_end, f_last_row, f_last_level;
  logic [tcmp_pkg::DataW-1:0]   rd_first, rd_second;
  logic [tcmp_pkg::QCntW:0]     in_flight;

  assign in_flight = (tcmp_pkg::QCntW + 1)'(q_count) + (tcmp_pkg::QCntW + 1)'(f_valid);
  assign feed.ready = in_flight < (tcmp_pkg::QCntW + 1)'(tcmp_pkg::QDepth);
  assign accept    = feed.valid && feed.ready;
  assign take_load = accept && (feed.opcode == tcmp_pkg::OpLoad);
  assign take_data = accept && (feed.opcode == tcmp_pkg::OpData);

  assign cols   = tcmp_pkg::eff_columns(cfg.row_length);
  assign rows   = (cfg.row_count == '0) ? tcmp_pkg::RowCntW'(1) : cfg.row_count;
  assign levels = (cfg.level_count == '0) ? tcmp_pkg::LvlCntW'(1) : cfg.level_count;

  assign row_end = (tcmp_pkg::ColCntW'(col_pos) + tcmp_pkg::ColCntW'(1)) >= cols;
  assign last_row = ({1'b0, row_pos} + (tcmp_pkg::RowCntW + 1)'(1))
                    >= {1'b0, rows};
  assign last_level = ({1'b0, lvl_pos} + (tcmp_pkg::LvlCntW + 1)'(1))
                      >= {1'b0, levels};

  always_comb begin
    load_ptr_next = load_ptr;
    col_pos_next  = col_pos;
    row_pos_next  = row_pos;
    lvl_pos_next  = lvl_pos;
    if (take_load) begin
      if ((tcmp_pkg::ColCntW'(load_ptr) + tcmp_pkg::ColCntW'(1)) >= cols) begin
        load_ptr_next = '0;
      end else begin
        load_ptr_next = load_ptr + tcmp_pkg::ColIdxW'(1);
      end
    end
    if (take_data) begin
      if (!row_end) begin
        col_pos_next = col_pos + tcmp_pkg::ColIdxW'(1);
      end else begin
        col_pos_next = '0;
        if (last_row) begin
          row_pos_next = '0;
          lvl_pos_next = last_level ? '0 : lvl_pos + tcmp_pkg::LvlCntW'(1);
        end else begin
          row_pos_next = row_pos + tcmp_pkg::RowCntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_ptr <= '0;
      col_pos  <= '0;
      row_pos  <= '0;
      lvl_pos  <= '0;
      f_valid  <= 1'b0;
    end else begin
      load_ptr <= load_ptr_next;
      col_pos  <= col_pos_next;
      row_pos  <= row_pos_next;
      lvl_pos  <= lvl_pos_next;
      f_valid  <= take_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take_data) begin
      f_db         <= feed.db_value;
      f_row_end    <= row_end;
      f_last_row   <= last_row;
      f_last_level <= last_level;
    end
  end

  tcmp_ram #(.Width(tcmp_pkg::DataW), .Depth(tcmp_pkg::MaxColumns)) u_first_store (
    .clk   (clk),
    .we    (take_load),
    .waddr (load_ptr),
    .wdata (feed.query_first),
    .re    (take_data),
    .raddr (col_pos),
    .rdata (rd_first)
  );

  tcmp_ram #(.Width(tcmp_pkg::DataW), .Depth(tcmp_pkg::MaxColumns)) u_second_store (
    .clk   (clk),
    .we    (take_load),
    .waddr (load_ptr),
    .wdata (feed.query_second),
    .re    (take_data),
    .raddr (col_pos),
    .rdata (rd_second)
  );

  assign push = f_valid;
  always_comb begin
    push_entry.db_value     = f_db;
    push_entry.query_first  = rd_first;
    push_entry.query_second = rd_second;
    push_entry.row_end      = f_row_end && f_valid;
    push_entry.level_done   = f_last_row;
    push_entry.final_level  = f_last_level;
  end

endmodule

[rtl/tcmp_fifo.sv]
// Short queue between front and back end.
// Depends on tcmp_pkg.
module tcmp_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  tcmp_pkg::qentry_t          push_entry,
  input  logic                       pop,
  output tcmp_pkg::qentry_t          head,
  output logic [tcmp_pkg::QCntW-1:0] count
);

  tcmp_pkg::qentry_t             slots [tcmp_pkg::QDepth];
  logic [tcmp_pkg::QPtrW-1:0]    wr_ptr, rd_ptr;

  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tcmp_pkg::QPtrW'(tcmp_pkg::QDepth - 1)) ? '0
                  : wr_ptr + tcmp_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tcmp_pkg::QPtrW'(tcmp_pkg::QDepth - 1)) ? '0
                  : rd_ptr + tcmp_pkg::QPtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + tcmp_pkg::QCntW'(1);
        2'b01:   count <= count - tcmp_pkg::QCntW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

[rtl/tcmp_back.sv]
// Back end: split 64x64 multiplies into 32x32 partial products, combine them,
// accumulate per row and hold the row result in the output register.
// Depends on tcmp_pkg and tcmp_sums_if.
module tcmp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  tcmp_pkg::qentry_t          head,
  input  logic [tcmp_pkg::QCntW-1:0] q_count,
  output logic                       pop,
  tcmp_sums_if.source                sums
);

  localparam int DataW = tcmp_pkg::DataW;
  localparam int HalfW = tcmp_pkg::HalfW;
  localparam int AccW  = tcmp_pkg::AccW;

  logic                advance;
  logic                v0, v1;
  logic [DataW-1:0]    pp_f [4];
  logic [DataW-1:0]    pp_s [4];
  logic                s0_row_end, s0_level_done, s0_final_level;
  logic [AccW-1:0]     prod_f, prod_s;
  logic                s1_row_end, s1_level_done, s1_final_level;
  logic [AccW-1:0]     acc_f, acc_s, sum_f, sum_s;
  logic [AccW-1:0]     out_f, out_s;
  logic                out_level_done, out_final_level;

  assign advance = !sums.valid || sums.ready;
  assign pop     = advance && (q_count != '0);

  always_ff @(posedge clk) begin
    if (advance && pop) begin
      pp_f[0] <= DataW'(head.db_value[HalfW-1:0] * head.query_first[HalfW-1:0]);
      pp_f[1] <= DataW'(head.db_value[HalfW-1:0] * head.query_first[DataW-1:HalfW]);
      pp_f[2] <= DataW'(head.db_value[DataW-1:HalfW] * head.query_first[HalfW-1:0]);
      pp_f[3] <= DataW'(head.db_value[DataW-1:HalfW] * head.query_first[DataW-1:HalfW]);
      pp_s[0] <= DataW'(head.db_value[HalfW-1:0] * head.query_second[HalfW-1:0]);
      pp_s[1] <= DataW'(head.db_value[HalfW-1:0] * head.query_second[DataW-1:HalfW]);
      pp_s[2] <= DataW'(head.db_value[DataW-1:HalfW] * head.query_second[HalfW-1:0]);
      pp_s[3] <= DataW'(head.db_value[DataW-1:HalfW] * head.query_second[DataW-1:HalfW]);
      s0_row_end     <= head.row_end;
      s0_level_done  <= head.level_done;
      s0_final_level <= head.final_level;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v0) begin
      prod_f <= {pp_f[3], pp_f[0]} + {HalfW'(0), pp_f[1], HalfW'(0)}
                + {HalfW'(0), pp_f[2], HalfW'(0)};
      prod_s <= {pp_s[3], pp_s[0]} + {HalfW'(0), pp_s[1], HalfW'(0)}
                + {HalfW'(0), pp_s[2], HalfW'(0)};
      s1_row_end     <= s0_row_end;
      s1_level_done  <= s0_level_done;
      s1_final_level <= s0_final_level;
    end
  end

  assign sum_f = acc_f + prod_f;
  assign sum_s = acc_s + prod_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0         <= 1'b0;
      v1         <= 1'b0;
      acc_f      <= '0;
      acc_s      <= '0;
      sums.valid <= 1'b0;
    end else if (advance) begin
      v0         <= pop;
      v1         <= v0;
      sums.valid <= v1 && s1_row_end;
      if (v1) begin
        acc_f <= s1_row_end ? '0 : sum_f;
        acc_s <= s1_row_end ? '0 : sum_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v1 && s1_row_end) begin
      out_f           <= sum_f;
      out_s           <= sum_s;
      out_level_done  <= s1_level_done;
      out_final_level <= s1_final_level;
    end
  end

  assign sums.first_sum_low   = out_f[DataW-1:0];
  assign sums.first_sum_high  = out_f[AccW-1:DataW];
  assign sums.second_sum_low  = out_s[DataW-1:0];
  assign sums.second_sum_high = out_s[AccW-1:DataW];
  assign sums.level_done      = out_level_done;
  assign sums.final_level     = out_final_level;

endmodule

[rtl/two_column_matrix_product_wide.sv]
// Two-column matrix product, top level: register port, front end, queue, back end.
// Row path: front register, queue, product stage, combine stage, output register.
// Throughput: one item per cycle unless results stall; the 32x32 partial-product
// multipliers are pipelined; a four-entry queue sets how far the front runs ahead.
// Reset (synchronous): positions, accumulators, queue and valids clear;
// registers return to one; query stores are not cleared.
module two_column_matrix_product_wide (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcmp_pkg::ApbAddrW-1:0] paddr,
  input  logic [tcmp_pkg::ApbDataW-1:0] pwdata,
  output logic [tcmp_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  tcmp_feed_if.sink                     feed,
  tcmp_sums_if.source                   sums
);

  tcmp_pkg::cfg_t                 cfg;
  logic                           cfg_write;
  logic                           push, pop;
  tcmp_pkg::qentry_t              push_entry, head;
  logic [tcmp_pkg::QCntW-1:0]     q_count;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_length  <= tcmp_pkg::RowLenW'(1);
      cfg.row_count   <= tcmp_pkg::RowCntW'(1);
      cfg.level_count <= tcmp_pkg::LvlCntW'(1);
    end else if (cfg_write) begin
      case (paddr[3:2])
        tcmp_pkg::RegRowLength:  cfg.row_length  <= pwdata[tcmp_pkg::RowLenW-1:0];
        tcmp_pkg::RegRowCount:   cfg.row_count   <= pwdata[tcmp_pkg::RowCntW-1:0];
        tcmp_pkg::RegLevelCount: cfg.level_count <= pwdata[tcmp_pkg::LvlCntW-1:0];
        default:                 cfg.row_length  <= cfg.row_length;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tcmp_pkg::RegRowLength:  prdata = tcmp_pkg::ApbDataW'(cfg.row_length);
      tcmp_pkg::RegRowCount:   prdata = tcmp_pkg::ApbDataW'(cfg.row_count);
      tcmp_pkg::RegLevelCount: prdata = tcmp_pkg::ApbDataW'(cfg.level_count);
      default:                 prdata = '0;
    endcase
  end

  tcmp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .feed       (feed),
    .q_count    (q_count),
    .push       (push),
    .push_entry (push_entry)
  );

  tcmp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .count      (q_count)
  );

  tcmp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_count (q_count),
    .pop     (pop),
    .sums    (sums)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> q_count < tcmp_pkg::QCntW'(tcmp_pkg::QDepth))
    else $error("queue push without room");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_count != '0)
    else $error("queue pop while empty");

  a_load_no_push: assert property (@(posedge clk) disable iff (rst)
    (feed.valid && feed.ready && feed.opcode == tcmp_pkg::OpLoad) |=> !push)
    else $error("query load reached the queue");

endmodule
